// File: rtl/core/cb64_pkg.sv
package cb64_pkg;

	localparam logic [15:0] CHUNK_BYTES_RESET = 16'd3200;
	localparam logic [7:0]  PAD_CHAR          = 8'h3D;
	localparam logic [7:0]  CHAR_UPPER_A      = 8'h41;
	localparam logic [7:0]  CHAR_LOWER_A      = 8'h61;
	localparam logic [7:0]  CHAR_DIGIT_0      = 8'h30;
	localparam logic [7:0]  CHAR_PLUS         = 8'h2B;
	localparam logic [7:0]  CHAR_SLASH        = 8'h2F;

	// Characters produced by one input byte, first character in slot 0
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            chunk_end;
	} group_t;

	// Map a 6-bit value onto the standard Base64 alphabet
	function automatic logic [7:0] enc6(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] c;
		w = {2'b00, v};
		case (v) inside
			[6'd0:6'd25]:  c = CHAR_UPPER_A + w;
			[6'd26:6'd51]: c = CHAR_LOWER_A + (w - 8'd26);
			[6'd52:6'd61]: c = CHAR_DIGIT_0 + (w - 8'd52);
			6'd62:         c = CHAR_PLUS;
			default:       c = CHAR_SLASH;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/cb64_encode.sv
module cb64_encode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  logic             end_of_stream,
	input  logic [15:0]      chunk_bytes,
	input  logic             advance,
	output cb64_pkg::group_t grp
);
	import cb64_pkg::*;

	logic [3:0]  held_q;
	logic [1:0]  phase_q;
	logic [15:0] count_q;

	logic [3:0]  held_n;
	logic [1:0]  phase_n;
	logic [15:0] count_n;
	logic        ended;

	always_comb begin
		grp       = '0;
		held_n    = '0;
		phase_n   = '0;
		count_n   = count_q + 16'd1;
		ended     = end_of_stream || (count_n >= chunk_bytes);
		case (phase_q)
			2'd1: begin
				grp.chars[0] = enc6({held_q[1:0], data_byte[7:4]});
				held_n       = data_byte[3:0];
				phase_n      = 2'd2;
				grp.last_idx = 2'd0;
			end
			2'd2: begin
				grp.chars[0] = enc6({held_q, data_byte[7:6]});
				grp.chars[1] = enc6(data_byte[5:0]);
				phase_n      = 2'd0;
				grp.last_idx = 2'd1;
			end
			default: begin
				grp.chars[0] = enc6(data_byte[7:2]);
				held_n       = {2'b00, data_byte[1:0]};
				phase_n      = 2'd1;
				grp.last_idx = 2'd0;
			end
		endcase
		grp.chunk_end = ended;
		if (ended) begin
			// flush leftover bits, then pad to a multiple of four
			if (phase_n == 2'd1) begin
				grp.chars[1] = enc6({held_n[1:0], 4'b0000});
				grp.chars[2] = PAD_CHAR;
				grp.chars[3] = PAD_CHAR;
				grp.last_idx = 2'd3;
			end else if (phase_n == 2'd2) begin
				grp.chars[1] = enc6({held_n, 2'b00});
				grp.chars[2] = PAD_CHAR;
				grp.last_idx = 2'd2;
			end
			held_n  = '0;
			phase_n = '0;
			count_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			phase_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			held_q  <= held_n;
			phase_q <= phase_n;
			count_q <= count_n;
		end
	end

endmodule

// File: rtl/core/cb64_serializer.sv
module cb64_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             grp_valid,
	output logic             grp_ready,
	input  cb64_pkg::group_t grp,
	output logic             char_valid,
	input  logic             char_ready,
	output logic [7:0]       out_char,
	output logic             last_of_item,
	output logic             chunk_end
);
	import cb64_pkg::*;

	group_t     buf_q;
	logic [1:0] idx_q;
	logic       full_q;
	logic       take;
	logic       done;
	logic       load;

	assign take      = full_q && char_ready;
	assign done      = take && (idx_q == buf_q.last_idx);
	assign grp_ready = !full_q || done;
	assign load      = grp_valid && grp_ready;

	assign char_valid   = full_q;
	assign out_char     = buf_q.chars[idx_q];
	assign last_of_item = (idx_q == buf_q.last_idx);
	assign chunk_end    = last_of_item && buf_q.chunk_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			full_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			full_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= grp;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> idx_q <= buf_q.last_idx)
		else $error("character index past end of group");
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && chunk_end |-> last_of_item)
		else $error("chunk end without last character of item");
	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> full_q && idx_q == 2'd0)
		else $error("loaded group does not start at first character");
`endif

endmodule

// File: rtl/core/chunked_base64_encoder.sv
// Chunked Base64 encoder.
// Input channel: byte_valid / byte_ready carry data_byte and end_of_stream;
// a transaction moves one raw byte. Output channel: char_valid / char_ready
// carry out_char with last_of_item (final character of that byte) and
// chunk_end (final character of an encoded chunk, padding included).
// Configuration: cfg_we writes cfg_wdata into the chunk size at once.
// Each byte yields one to four characters. The byte lands in an input
// register; once the output buffer is free the encoder builds its whole
// character group into that buffer, which then shows the first character
// on char_valid. Throughput is set by the output buffer, which drains
// one character a cycle while char_ready is high; a byte yields about
// 1.33 characters on average and up to four at a chunk end. The input
// register takes the next byte while the buffer drains.
// When the receiver stalls, the buffer holds its character and the input
// register holds one more byte; byte_ready drops whenever the input
// register holds a byte that the buffer cannot take yet.
// Reset clears the group state, the chunk counter and all valid flags, and
// sets the chunk size to 3200 bytes.
module chunked_base64_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        char_valid,
	input  logic        char_ready,
	output logic [7:0]  out_char,
	output logic        last_of_item,
	output logic        chunk_end
);
	import cb64_pkg::*;

	logic [15:0] chunk_bytes_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        grp_ready;
	logic        advance;
	group_t      grp;

	// advance the encoder state when the input register hands its byte on
	assign advance    = valid_s1 && grp_ready;
	assign byte_ready = !valid_s1 || grp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bytes_q <= CHUNK_BYTES_RESET;
		end else if (cfg_we) begin
			chunk_bytes_q <= cfg_wdata;
		end
	end

	// input register: hold the byte until the output buffer takes its group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= data_byte;
			eos_s1  <= end_of_stream;
		end
	end

	cb64_encode u_encode (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (byte_s1),
		.end_of_stream (eos_s1),
		.chunk_bytes   (chunk_bytes_q),
		.advance       (advance),
		.grp           (grp)
	);

	cb64_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp_valid    (valid_s1),
		.grp_ready    (grp_ready),
		.grp          (grp),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.out_char     (out_char),
		.last_of_item (last_of_item),
		.chunk_end    (chunk_end)
	);

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import cb64_pkg::*;

	localparam int MAX_CYCLES = 200000;
	// Receiver hold-off long enough to fill the output buffer and the input register
	localparam int BACKPRESSURE_CYCLES = 150;
	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// One raw byte transaction on the input channel
	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} raw_byte_t;

	// One character transaction on the output channel
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       cend;
	} b64_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	logic [7:0]  data_byte = '0;
	logic        end_of_stream = 1'b0;
	logic        char_valid;
	logic        char_ready = 1'b0;
	logic [7:0]  out_char;
	logic        last_of_item;
	logic        chunk_end;

	raw_byte_t   byte_q[$];      // bytes waiting to be offered
	b64_out_t    char_q[$];      // characters the encoder still owes us

	// Shadow of the encoder state and its chunk size register
	logic [15:0] cfg_chunk = CHUNK_BYTES_RESET;
	logic [3:0]  rem_bits = '0;
	logic [1:0]  grp_pos = '0;
	logic [15:0] chunk_fill = '0;

	logic        byte_taken = 1'b0;
	int          errors = 0;
	int          cycles = 0;
	int          idle_pct = 7;
	int          stall_reqs = 0;
	int          stall_seen = 0;
	int          hold_left = 0;

	chunked_base64_encoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.out_char     (out_char),
		.last_of_item (last_of_item),
		.chunk_end    (chunk_end)
	);

	always #4 clk = ~clk;

	// Look a 6-bit value up in the alphabet; first character sits in the top byte
	function automatic logic [7:0] b64_sym(input logic [5:0] v);
		return B64_ALPHABET[(63 - int'(v)) * 8 +: 8];
	endfunction

	// Advance the shadow state by one byte and queue the characters it yields
	function automatic void encode_byte(input raw_byte_t it);
		logic [7:0] syms [4];
		int         n;
		logic       done;
		b64_out_t   r;
		n = 0;
		case (grp_pos)
			2'd1: begin
				syms[0] = b64_sym({rem_bits[1:0], it.data[7:4]});
				n = 1;
				rem_bits = it.data[3:0];
				grp_pos = 2'd2;
			end
			2'd2: begin
				syms[0] = b64_sym({rem_bits, it.data[7:6]});
				syms[1] = b64_sym(it.data[5:0]);
				n = 2;
				rem_bits = '0;
				grp_pos = 2'd0;
			end
			default: begin
				syms[0] = b64_sym(it.data[7:2]);
				n = 1;
				rem_bits = {2'b00, it.data[1:0]};
				grp_pos = 2'd1;
			end
		endcase

		// A chunk size of zero makes every byte a chunk of its own
		chunk_fill = chunk_fill + 16'd1;
		done = it.eos || (chunk_fill >= cfg_chunk);
		if (done) begin
			// Flush the leftover bits zero-padded, then pad to four characters
			if (grp_pos == 2'd1) begin
				syms[n]     = b64_sym({rem_bits[1:0], 4'b0000});
				syms[n + 1] = PAD_CHAR;
				syms[n + 2] = PAD_CHAR;
				n = n + 3;
			end else if (grp_pos == 2'd2) begin
				syms[n]     = b64_sym({rem_bits, 2'b00});
				syms[n + 1] = PAD_CHAR;
				n = n + 2;
			end
			rem_bits = '0;
			grp_pos = 2'd0;
			chunk_fill = '0;
		end

		for (int k = 0; k < n; k++) begin
			r.ch   = syms[k];
			r.last = (k == n - 1);
			r.cend = done && (k == n - 1);
			char_q.insert(char_q.size(), r);
		end
	endfunction

	function automatic raw_byte_t rand_byte(input int eos_pct);
		raw_byte_t it;
		it.data = 8'($urandom);
		it.eos  = ($urandom_range(99) < eos_pct);
		return it;
	endfunction

	task automatic offer(input logic [7:0] d, input logic e);
		raw_byte_t it;
		it.data = d;
		it.eos  = e;
		byte_q.insert(byte_q.size(), it);
	endtask

	// Write the chunk size; only called while the encoder is idle
	task automatic set_chunk(input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		cfg_chunk = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every byte is taken and every character has come back
	task automatic drain();
		while (byte_q.size() != 0 || byte_valid || char_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Record input transactions and predict their characters
	always @(posedge clk) begin
		byte_taken <= byte_valid && byte_ready;
		if (byte_valid && byte_ready)
			encode_byte('{data_byte, end_of_stream});
	end

	// Sender: offer the next byte once the current one is taken, idling at random
	always @(negedge clk) begin : byte_driver
		raw_byte_t nxt;
		if (arst_n && (!byte_valid || byte_taken)) begin
			if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = byte_q.pop_front();
				byte_valid <= 1'b1;
				data_byte <= nxt.data;
				end_of_stream <= nxt.eos;
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin : char_sink
		logic rdy;
		if (stall_seen != stall_reqs) begin
			stall_seen = stall_reqs;
			hold_left = BACKPRESSURE_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else begin
			rdy = ($urandom_range(99) >= idle_pct);
		end
		char_ready <= rdy;
	end

	// Check each character transaction against the oldest prediction
	always @(posedge clk) begin : char_check
		b64_out_t want;
		if (char_valid && char_ready) begin
			if (char_q.size() == 0) begin
				$error("out_char: expected nothing, actual %h", out_char);
				errors++;
			end else begin
				want = char_q.pop_front();
				if (out_char !== want.ch) begin
					$error("out_char: expected %h, actual %h", want.ch, out_char);
					errors++;
				end
				if (last_of_item !== want.last) begin
					$error("last_of_item: expected %b, actual %b", want.last, last_of_item);
					errors++;
				end
				if (chunk_end !== want.cend) begin
					$error("chunk_end: expected %b, actual %b", want.cend, chunk_end);
					errors++;
				end
			end
		end
	end

	// Watchdog: drop the run if it hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		raw_byte_t  it;
		logic [15:0] sz;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset chunk size: all-zero, all-one and the '+' characters
		offer(8'h00, 1'b0); offer(8'h00, 1'b0); offer(8'h00, 1'b0);
		offer(8'hFF, 1'b0); offer(8'hFF, 1'b0); offer(8'hFF, 1'b0);
		offer(8'hFB, 1'b0); offer(8'hEF, 1'b0); offer(8'hBE, 1'b0);
		// End of stream after one, two and three bytes of a group
		offer(8'h01, 1'b1);
		offer(8'h12, 1'b0); offer(8'h34, 1'b1);
		offer(8'h56, 1'b0); offer(8'h78, 1'b0); offer(8'h9A, 1'b1);
		drain();

		// Chunk size zero behaves like one
		set_chunk(16'd0);
		offer(8'hA5, 1'b0); offer(8'h5A, 1'b0); offer(8'hC3, 1'b0);
		drain();

		set_chunk(16'd1);
		offer(8'h3C, 1'b0); offer(8'hFF, 1'b1);
		drain();

		// Largest chunk, then lower the size below the count mid-chunk
		set_chunk(16'hFFFF);
		for (int i = 0; i < 5; i++)
			offer(8'(8'h10 + i), 1'b0);
		drain();
		set_chunk(16'd2);
		offer(8'h6B, 1'b0); offer(8'hD2, 1'b0);
		drain();

		// Random phases over assorted chunk sizes
		for (int p = 0; p < 6; p++) begin
			case ($urandom_range(4))
				0: sz = 16'd0;
				1: sz = 16'($urandom_range(1, 4));
				2: sz = 16'($urandom_range(5, 40));
				3: sz = 16'hFFFF;
				default: sz = 16'($urandom_range(41, 4000));
			endcase
			set_chunk(sz);
			// Keep two phases free of idling; in the second of them stall the receiver
			// while the sender keeps offering, so the input backs up
			idle_pct = (p == 2 || p == 3) ? 0 : 7;
			for (int i = 0; i < 40; i++) begin
				it = rand_byte(6);
				byte_q.insert(byte_q.size(), it);
			end
			if (p == 3)
				stall_reqs++;
			drain();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/cb64_pkg.sv
rtl/core/cb64_encode.sv
rtl/core/cb64_serializer.sv
rtl/core/chunked_base64_encoder.sv
test/tb.sv
